>>> hw/rtl/fir_pkg.sv
// ============================================================================
// FIR filter package
// Shared constants, request and result types, and control types for the
// digit-serial FIR filter.
// ============================================================================
package fir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int TAP_CFG_W    = 7;
    localparam int COEF_IDX_W   = 6;
    localparam int MAX_TAPS_DEF = 64;
    localparam int DIGIT_W      = 4;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [PADDR_W-1:0] ADDR_TAP_COUNT = 3'd0;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_ROUND,
        ST_DONE
    } fir_state_t;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [COEF_IDX_W-1:0]      coef_index;
        logic signed [SAMPLE_W-1:0] coef_value;
    } fir_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_sample;
        logic                       saturated;
    } fir_rsp_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic last;
    } fir_mac_ctrl_t;

endpackage

>>> hw/rtl/fir_mac.sv
// ============================================================================
// FIR digit-serial multiply-accumulate
// Multiplies a sample by a coefficient one coefficient digit per cycle while
// step is high, and adds the partial products into a wide accumulator.
// ============================================================================
module fir_mac #(
    parameter int ACC_W = 2 * fir_pkg::SAMPLE_W + 8
) (
    input  logic                               clk,
    input  fir_pkg::fir_mac_ctrl_t             ctrl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] coef,
    output logic signed [ACC_W-1:0]            acc
);

    localparam int D     = fir_pkg::DIGIT_W;
    localparam int NDIG  = (fir_pkg::SAMPLE_W + D - 1) / D;
    localparam int MPL_W = NDIG * D;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] mcand_reg;
    logic [MPL_W-1:0]        mplier_reg;
    logic signed [D:0]       digit;
    logic signed [ACC_W-1:0] pp;
    logic signed [MPL_W-1:0] coef_ext;

    assign coef_ext = MPL_W'(coef);
    assign digit    = ctrl.last ? $signed({mplier_reg[D-1], mplier_reg[D-1:0]})
                                : $signed({1'b0, mplier_reg[D-1:0]});
    assign pp       = mcand_reg * ACC_W'(digit);

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.step)
        begin
            acc_reg <= acc_reg + pp;
        end
        if (ctrl.load)
        begin
            mcand_reg  <= ACC_W'(sample);
            mplier_reg <= coef_ext;
        end
        else if (ctrl.step)
        begin
            mcand_reg  <= mcand_reg <<< D;
            mplier_reg <= mplier_reg >> D;
        end
    end

    assign acc = acc_reg;

endmodule

>>> hw/rtl/fir_filter.sv
// ============================================================================
// FIR filter top level
// Direct-form FIR filter with circular sample history, coefficient memory,
// a single digit-serial multiply-accumulate, rounding and saturation.
// ============================================================================
// A sample request passes ST_READ, ST_LOAD and ST_MUL for each of the T taps in
// use (none when T is 0), then ST_ROUND and ST_DONE, which waits for a free
// output register. Requests are taken only in ST_IDLE; a coefficient request
// gives no result. Each tap does a memory read, an operand load and one step
// per 4-bit digit of its 16-bit weight in the shared multiply-accumulate.
// After reset the history and coefficients read as zero and tap_count is 1.
module fir_filter #(
    parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  fir_pkg::fir_req_t              req_word,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output fir_pkg::fir_rsp_t              rsp_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fir_pkg::PADDR_W-1:0]    paddr,
    input  logic [fir_pkg::PDATA_W-1:0]    pwdata,
    output logic [fir_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int W      = fir_pkg::SAMPLE_W;
    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_W  = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = 2 * W + $clog2(MAX_TAPS) + 1;
    localparam int NDIG   = (W + fir_pkg::DIGIT_W - 1) / fir_pkg::DIGIT_W;
    localparam int DCNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (W - 2);
    localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(1) <<< (W - 1));

    localparam int TAP_CFG_W_L = fir_pkg::TAP_CFG_W;

    fir_pkg::fir_state_t state_reg, state_next;

    logic [TAP_CFG_W_L-1:0] tap_count_reg;

    logic signed [W-1:0]     hist_mem [MAX_TAPS];
    logic signed [W-1:0]     coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]     hist_vld_reg;
    logic [MAX_TAPS-1:0]     coef_vld_reg;
    logic signed [W-1:0]     hist_rd_reg;
    logic signed [W-1:0]     coef_rd_reg;
    logic                    hist_vrd_reg;
    logic                    coef_vrd_reg;

    logic [ADDR_W-1:0]       wp_reg, wp_next;
    logic [ADDR_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [TAP_W-1:0]        tap_idx_reg, tap_idx_next;
    logic [DCNT_W-1:0]       dig_cnt_reg, dig_cnt_next;
    logic signed [W-1:0]     sample_reg;
    logic signed [ACC_W-1:0] acc_rnd_reg;

    logic                    out_valid_reg;
    fir_pkg::fir_rsp_t       out_data_reg;

    logic                    req_acc;
    logic                    cfg_we;
    logic                    coef_we;
    logic                    hist_we;
    logic                    out_load;
    logic                    out_free;
    logic [31:0]             taps_full;
    logic [TAP_W-1:0]        taps;
    logic [TAP_W:0]          wp_ext;
    logic [TAP_W:0]          taps_ext;
    logic [TAP_W:0]          start_ext;
    logic [ADDR_W-1:0]       wrap_addr;
    logic                    tap_last;
    logic                    dig_last;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] y_full;
    fir_pkg::fir_mac_ctrl_t  mac_ctrl;
    logic signed [W-1:0]     mac_sample;
    logic signed [W-1:0]     mac_coef;

    assign pready  = 1'b1;
    assign prdata  = (paddr == fir_pkg::ADDR_TAP_COUNT) ? fir_pkg::PDATA_W'(tap_count_reg) : '0;
    assign cfg_we  = psel && penable && pwrite && (paddr == fir_pkg::ADDR_TAP_COUNT);

    assign req_stall = (state_reg != fir_pkg::ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign coef_we   = req_acc && (req_word.cmd == fir_pkg::CMD_COEF)
                       && (32'(req_word.coef_index) < 32'(MAX_TAPS));

    assign taps_full = (32'(tap_count_reg) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS)
                                                            : 32'(tap_count_reg);
    assign taps      = taps_full[TAP_W-1:0];
    assign wp_ext    = (TAP_W + 1)'(wp_reg);
    assign taps_ext  = (TAP_W + 1)'(taps);
    assign start_ext = (wp_ext >= taps_ext) ? (wp_ext - taps_ext)
                                            : (wp_ext + (TAP_W + 1)'(MAX_TAPS) - taps_ext);
    assign wrap_addr = ADDR_W'(MAX_TAPS - 1);
    assign tap_last  = ((tap_idx_reg + TAP_W'(1)) == taps);
    assign dig_last  = (dig_cnt_reg == DCNT_W'(NDIG - 1));
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign mac_sample = hist_vrd_reg ? hist_rd_reg : '0;
    assign mac_coef   = coef_vrd_reg ? coef_rd_reg : '0;
    assign y_full     = acc_rnd_reg >>> (W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fir_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tap_idx_next = tap_idx_reg;
        dig_cnt_next = dig_cnt_reg;
        rd_addr_next = rd_addr_reg;
        wp_next      = wp_reg;
        mac_ctrl     = '0;
        hist_we      = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            fir_pkg::ST_IDLE:
            begin
                if (req_acc && (req_word.cmd == fir_pkg::CMD_SAMPLE))
                begin
                    mac_ctrl.clear = 1'b1;
                    tap_idx_next   = '0;
                    rd_addr_next   = ADDR_W'(start_ext);
                    state_next     = (taps == '0) ? fir_pkg::ST_ROUND : fir_pkg::ST_READ;
                end
            end
            fir_pkg::ST_READ:
            begin
                state_next = fir_pkg::ST_LOAD;
            end
            fir_pkg::ST_LOAD:
            begin
                mac_ctrl.load = 1'b1;
                dig_cnt_next  = '0;
                state_next    = fir_pkg::ST_MUL;
            end
            fir_pkg::ST_MUL:
            begin
                mac_ctrl.step = 1'b1;
                mac_ctrl.last = dig_last;
                dig_cnt_next  = dig_cnt_reg + DCNT_W'(1);
                if (dig_last)
                begin
                    if (tap_last)
                    begin
                        state_next = fir_pkg::ST_ROUND;
                    end
                    else
                    begin
                        tap_idx_next = tap_idx_reg + TAP_W'(1);
                        rd_addr_next = (rd_addr_reg == wrap_addr) ? '0
                                                                  : rd_addr_reg + ADDR_W'(1);
                        state_next   = fir_pkg::ST_READ;
                    end
                end
            end
            fir_pkg::ST_ROUND:
            begin
                state_next = fir_pkg::ST_DONE;
            end
            fir_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    hist_we    = 1'b1;
                    out_load   = 1'b1;
                    wp_next    = (wp_reg == wrap_addr) ? '0 : wp_reg + ADDR_W'(1);
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_CFG_W_L'(1);
            hist_vld_reg  <= '0;
            coef_vld_reg  <= '0;
            wp_reg        <= '0;
            rd_addr_reg   <= '0;
            tap_idx_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_addr_reg <= rd_addr_next;
            tap_idx_reg <= tap_idx_next;
            dig_cnt_reg <= dig_cnt_next;
            if (cfg_we)
            begin
                tap_count_reg <= pwdata[TAP_CFG_W_L-1:0];
                hist_vld_reg  <= '0;
                wp_reg        <= '0;
            end
            else
            begin
                wp_reg <= wp_next;
                if (hist_we)
                begin
                    hist_vld_reg[wp_reg] <= 1'b1;
                end
            end
            if (coef_we)
            begin
                coef_vld_reg[ADDR_W'(req_word.coef_index)] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hist_rd_reg  <= hist_mem[rd_addr_reg];
        hist_vrd_reg <= hist_vld_reg[rd_addr_reg];
        coef_rd_reg  <= coef_mem[tap_idx_reg[ADDR_W-1:0]];
        coef_vrd_reg <= coef_vld_reg[tap_idx_reg[ADDR_W-1:0]];
        if (hist_we)
        begin
            hist_mem[wp_reg] <= sample_reg;
        end
        if (coef_we)
        begin
            coef_mem[ADDR_W'(req_word.coef_index)] <= req_word.coef_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            sample_reg <= req_word.sample_value;
        end
        if (state_reg == fir_pkg::ST_ROUND)
        begin
            acc_rnd_reg <= acc + HALF;
        end
        if (out_load)
        begin
            if (y_full > Y_MAX)
            begin
                out_data_reg.filtered_sample <= Y_MAX[W-1:0];
                out_data_reg.saturated       <= 1'b1;
            end
            else if (y_full < Y_MIN)
            begin
                out_data_reg.filtered_sample <= Y_MIN[W-1:0];
                out_data_reg.saturated       <= 1'b1;
            end
            else
            begin
                out_data_reg.filtered_sample <= y_full[W-1:0];
                out_data_reg.saturated       <= 1'b0;
            end
        end
    end

    fir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .sample (mac_sample),
        .coef   (mac_coef),
        .acc    (acc)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fir_pkg::ST_DONE))
        else $error("Result appeared without a finished computation.");

    a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rd_addr_reg) < 32'(MAX_TAPS))
        else $error("History read address out of range.");

    a_tap_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fir_pkg::ST_MUL) |-> (tap_idx_reg < taps))
        else $error("Tap index beyond tap count.");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req_word.cmd == fir_pkg::CMD_SAMPLE)) |=>
            (state_reg != fir_pkg::ST_IDLE))
        else $error("Sample request did not start a computation.");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// FIR filter testbench
// Drives sample and coefficient requests into the FIR filter with random
// gaps and result stalls. A scoreboard keeps its own filter model and checks
// every result field in order. The tap count is changed between phases.
// ============================================================================
class fir_scoreboard;
    logic signed [15:0] history [64];
    logic signed [15:0] coefs [64];
    int unsigned taps;
    fir_pkg::fir_rsp_t pending[$];
    int errors;

    function void reset_state();
        foreach (history[i]) history[i] = '0;
        foreach (coefs[i]) coefs[i] = '0;
        taps = 1;
        pending.delete();
        errors = 0;
    endfunction

    function void set_taps(int unsigned t);
        taps = t & 7'h7F;
        foreach (history[i]) history[i] = '0;
    endfunction

    function void note_request(fir_pkg::fir_req_t r);
        longint acc;
        longint y;
        int unsigned t;
        fir_pkg::fir_rsp_t e;
        if (r.cmd == fir_pkg::CMD_COEF)
        begin
            coefs[r.coef_index] = r.coef_value;
            return;
        end
        t = (taps > 64) ? 64 : taps;
        acc = 0;
        for (int k = 0; k < t; k++)
            acc += longint'(coefs[k]) * longint'(history[t - 1 - k]);
        y = (acc + (64'sd1 <<< 14)) >>> 15;
        if (t == 0) y = 0;
        e.saturated = 1'b0;
        if (y > 32767)
        begin
            y = 32767;
            e.saturated = 1'b1;
        end
        else if (y < -32768)
        begin
            y = -32768;
            e.saturated = 1'b1;
        end
        e.filtered_sample = y[15:0];
        for (int j = 63; j > 0; j--) history[j] = history[j - 1];
        history[0] = r.sample_value;
        pending.push_back(e);
    endfunction

    function void check_result(fir_pkg::fir_rsp_t a);
        fir_pkg::fir_rsp_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result %h", a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.filtered_sample !== e.filtered_sample)
        begin
            $error("filtered_sample expected %0d actual %0d", e.filtered_sample,
                   a.filtered_sample);
            errors++;
        end
        if (a.saturated !== e.saturated)
        begin
            $error("saturated expected %0d actual %0d", e.saturated, a.saturated);
            errors++;
        end
    endfunction
endclass

module tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    fir_pkg::fir_req_t req_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    fir_pkg::fir_rsp_t rsp_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [fir_pkg::PADDR_W-1:0] paddr = '0;
    logic [fir_pkg::PDATA_W-1:0] pwdata = '0;
    logic [fir_pkg::PDATA_W-1:0] prdata;
    logic pready;

    fir_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned hold_cycles = 0;
    int unsigned rx_wait = 0;
    bit random_stall = 1'b0;

    fir_filter i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("** fir_filter: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            sb.check_result(rsp_data);
            rx_wait = random_stall ? $urandom_range(0, 15) : 0;
        end
        else if (rx_wait > 0)
            rx_wait = rx_wait - 1;
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= (rx_wait > 0);
    end

    task automatic send_request(fir_pkg::fir_req_t r, bit gaps);
        int unsigned gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15)) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= r;
        do @(posedge clk); while (req_stall);
        sb.note_request(r);
    endtask

    task automatic send_sample(logic signed [15:0] v, bit gaps);
        fir_pkg::fir_req_t r;
        r = {fir_pkg::CMD_SAMPLE, v, 6'($urandom), 16'($urandom)};
        send_request(r, gaps);
    endtask

    task automatic send_coef(int idx, logic signed [15:0] v, bit gaps);
        fir_pkg::fir_req_t r;
        r = {fir_pkg::CMD_COEF, 16'($urandom), 6'(idx), v};
        send_request(r, gaps);
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        while (waited < 400)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic write_taps(int unsigned t);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= fir_pkg::ADDR_TAP_COUNT;
        pwdata <= t;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_taps(t);
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int tap_set [6];
        int t;
        tap_set = '{1, 64, 0, 3, 16, 100};
        sb = new();
        sb.reset_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sh7FFF, 0);
        send_coef(0, 16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh7FFF, 0);
        send_coef(0, 16'sh8000, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh0001, 0);
        drain();
        write_taps(2);
        send_coef(1, 16'sh8000, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh7FFF, 0);
        drain();
        write_taps(0);
        send_sample(16'sh1234, 0);
        send_sample(16'sh8000, 0);
        drain();

        random_stall = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_taps(tap_set[ph]);
            t = (tap_set[ph] > 64) ? 64 : tap_set[ph];
            for (int n = 0; n < ((t >= 16) ? 150 : 300); n++)
            begin
                if (n == 20)
                    hold_cycles = 3000;
                if ($urandom_range(0, 4) == 0)
                    send_coef($urandom_range(0, 63), rand_value(), 1);
                else
                    send_sample(rand_value(), 1);
            end
            drain();
        end

        drain();
        if (sb.errors == 0)
            $display("** fir_filter: PASSED **");
        else
            $display("** fir_filter: FAILED **");
        $finish;
    end
endmodule

>>> fir_filter.f
hw/rtl/fir_pkg.sv
hw/rtl/fir_mac.sv
hw/rtl/fir_filter.sv
dv/tb.sv
